### rtl/core/rcwd_pkg.sv
// ----------------------------------------------------------------------------
// rcwd_pkg
// Types and constants shared by the capture word run-length decoder.
// ----------------------------------------------------------------------------
package rcwd_pkg;

  localparam int unsigned WordsPerSlice = 8;
  localparam int unsigned SlotW         = $clog2(WordsPerSlice);
  localparam int unsigned PosW          = $clog2(WordsPerSlice + 1);
  localparam int unsigned WordW         = 32;
  localparam int unsigned NibW          = 4;
  localparam int unsigned FullW         = WordW + NibW;
  localparam int unsigned LenFollowsBit = 35;
  localparam int unsigned SampleW       = 34;
  localparam int unsigned RunW          = 37;
  localparam int unsigned LimitW        = 48;
  localparam int unsigned CountW        = 24;
  localparam int unsigned CfgIdxW       = 1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SAMPLE_LIMIT = 1'b0,
    REG_WORD_COUNT   = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_CALC = 4'b0100,
    S_CLIP = 4'b1000
  } dec_state_e;

  typedef struct packed {
    logic [WordW-1:0] mem_word;
    logic             capture_start;
  } in_item_t;

  typedef struct packed {
    logic [SampleW-1:0] sample_value;
    logic [RunW-1:0]    repeat_count;
    logic               last;
  } out_item_t;

endpackage

### rtl/core/rle_capture_word_decoder_unit.sv
// ----------------------------------------------------------------------------
// rle_capture_word_decoder_unit
// Run-length decoder for nine-word capture memory slices.
// ----------------------------------------------------------------------------
// Capture words arrive as requests on the input channel. The first eight words
// of a slice go into an 8x32 buffer RAM and are taken in one per cycle. The
// ninth word carries the high nibbles; on it the input closes and the decoder
// walks the buffer: a decoded word passes the RAM read, run/room compute and
// clip-and-accumulate steps, a skipped word stops after compute, and clip
// waits while the output is stalled. Each decoded word gives at most one
// result request, held in an output register; the next slice's first eight
// words are accepted while a result still waits. capture_start restarts the
// decoder at its word. The user must write sample_limit and word_count via the
// configuration channel only while idle; the block does not enforce this.
module rle_capture_word_decoder_unit
  import rcwd_pkg::*;
#(
  parameter int unsigned CHANNELS = 34
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [LimitW-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o
);

  dec_state_e           state_q, state_d;
  logic [PosW-1:0]      pos_q, pos_d, pos_eff;
  logic [SlotW-1:0]     idx_q, idx_d;
  logic [WordW-1:0]     nib_q, nib_d;
  logic                 lf_q, lf_d;
  logic [SampleW-1:0]   sample_q, sample_d;
  logic [LimitW-1:0]    emitted_q, emitted_d;
  logic [CountW-1:0]    wd_q, wd_d;
  logic                 fin_q, fin_d;
  logic [LimitW-1:0]    limit_q;
  logic [CountW-1:0]    wcount_q;
  logic [RunW-1:0]      run_q, run_d;
  logic [LimitW-1:0]    room_q, room_d;
  logic                 wc_hit_q, wc_hit_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_q, out_d;

  logic                 in_acc;
  logic                 ram_we;
  logic [WordW-1:0]     ram_rdata;
  logic [FullW-1:0]     full;
  logic                 skip;
  logic [LimitW-1:0]    clipped;
  logic                 last;
  logic                 emit;
  logic                 out_free;
  logic                 load_out;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign pos_eff     = in_data_i.capture_start ? '0 : pos_q;
  assign ram_we      = in_acc && (pos_eff < PosW'(WordsPerSlice));

  rcwd_ram #(
    .Width (WordW),
    .Depth (WordsPerSlice)
  ) u_slice_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pos_eff[SlotW-1:0]),
    .wdata_i (in_data_i.mem_word),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // word i takes nibble bits 31-4i..28-4i
  assign full = {nib_q[(WordW - NibW) - NibW * idx_q +: NibW], ram_rdata};
  assign skip = fin_q || (wd_q >= wcount_q);

  assign clipped  = (LimitW'(run_q) > room_q) ? room_q : LimitW'(run_q);
  // clipped reaches room exactly when the limit is hit
  assign last     = (clipped == room_q) || wc_hit_q;
  assign emit     = last || (clipped != '0);
  assign out_free = !out_valid_q || out_ready_i;
  assign load_out = (state_q == S_CLIP) && emit && out_free;

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    nib_d       = nib_q;
    lf_d        = lf_q;
    sample_d    = sample_q;
    emitted_d   = emitted_q;
    wd_d        = wd_q;
    fin_d       = fin_q;
    run_d       = run_q;
    room_d      = room_q;
    wc_hit_d    = wc_hit_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data_i.capture_start) begin
            lf_d      = 1'b0;
            sample_d  = '0;
            emitted_d = '0;
            wd_d      = '0;
            fin_d     = 1'b0;
          end
          if (pos_eff < PosW'(WordsPerSlice)) begin
            pos_d = pos_eff + PosW'(1);
          end else begin
            pos_d   = '0;
            nib_d   = in_data_i.mem_word;
            idx_d   = '0;
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        state_d = S_CALC;
      end
      S_CALC: begin
        if (skip) begin
          if (idx_q == SlotW'(WordsPerSlice - 1)) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + SlotW'(1);
            state_d = S_READ;
          end
        end else begin
          wd_d     = wd_q + CountW'(1);
          wc_hit_d = ((wd_q + CountW'(1)) == wcount_q);
          if (!lf_q) begin
            sample_d = SampleW'(full[CHANNELS-1:0]);
            run_d    = RunW'(full[CHANNELS]) + RunW'(1);
            lf_d     = full[LenFollowsBit];
          end else begin
            run_d = {full, 1'b0};
            lf_d  = 1'b0;
          end
          room_d  = (limit_q > emitted_q) ? (limit_q - emitted_q) : '0;
          state_d = S_CLIP;
        end
      end
      S_CLIP: begin
        if (!emit || out_free) begin
          emitted_d = emitted_q + clipped;
          if (last) begin
            fin_d = 1'b1;
          end
          if (emit) begin
            out_valid_d        = 1'b1;
            out_d.sample_value = sample_q;
            out_d.repeat_count = clipped[RunW-1:0];
            out_d.last         = last;
          end
          if (idx_q == SlotW'(WordsPerSlice - 1)) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + SlotW'(1);
            state_d = S_READ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      idx_q       <= '0;
      lf_q        <= 1'b0;
      sample_q    <= '0;
      emitted_q   <= '0;
      wd_q        <= '0;
      fin_q       <= 1'b0;
      limit_q     <= '1;
      wcount_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      idx_q       <= idx_d;
      lf_q        <= lf_d;
      sample_q    <= sample_d;
      emitted_q   <= emitted_d;
      wd_q        <= wd_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_SAMPLE_LIMIT: limit_q  <= cfg_data_i;
          REG_WORD_COUNT:   wcount_q <= cfg_data_i[CountW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    nib_q    <= nib_d;
    run_q    <= run_d;
    room_q   <= room_d;
    wc_hit_q <= wc_hit_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(WordsPerSlice))
    else $error("slice position out of range");

  a_walk_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (pos_q == '0))
    else $error("buffer walk with nonzero slice position");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_valid_q || out_ready_i))
    else $error("pending result overwritten");

  a_clip_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLIP) |-> (clipped <= room_q))
    else $error("clipped run exceeds room");

  a_last_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && last) |=> fin_q)
    else $error("last result without finish");

endmodule

### rtl/core/rcwd_ram.sv
// ----------------------------------------------------------------------------
// rcwd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rcwd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### dv/rle_capture_word_decoder_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rle_capture_word_decoder_unit_tb
// Drives nine-word capture slices into the run-length decoder and checks every
// decoded run against a cycle-free prediction of the sample, run and last flag.
// A short directed sequence hits the run extremes, clipping, early finish and
// a limit dropped to the samples already emitted. Random readouts follow,
// with random sample_limit / word_count settings, mid-slice restarts and noise.
// ----------------------------------------------------------------------------
module rle_capture_word_decoder_unit_tb;
  import rcwd_pkg::*;

  localparam int unsigned SettleCycles = 48;  // a walk of the 8 buffered words plus margin
  localparam int unsigned WordGoal     = 290;

  // Predicts the runs of one capture readout and holds those still due.
  class run_tracker;
    bit [LimitW-1:0]  limit_r = '1;
    bit [CountW-1:0]  count_r = '0;
    bit [WordW-1:0]   slice_words [WordsPerSlice];
    int unsigned      slot = 0;
    bit               len_next = 1'b0;
    bit [SampleW-1:0] cur_sample = '0;
    bit [LimitW-1:0]  emitted = '0;
    bit [CountW-1:0]  decoded = '0;
    bit               done = 1'b0;
    out_item_t        runs_due [$];
    int unsigned      mismatches = 0;
    int unsigned      runs_checked = 0;
    int unsigned      words_sent = 0;
    int unsigned      words_live = 0;
    int unsigned      zero_runs = 0;
    int unsigned      clip_hits = 0;
    int unsigned      capture_ends = 0;

    function void clear_capture();
      slot = 0;
      len_next = 1'b0;
      cur_sample = '0;
      emitted = '0;
      decoded = '0;
      done = 1'b0;
    endfunction

    function void write_reg(cfg_reg_e idx, bit [LimitW-1:0] val);
      case (idx)
        REG_SAMPLE_LIMIT: limit_r = val;
        REG_WORD_COUNT:   count_r = val[CountW-1:0];
        default: ;
      endcase
    endfunction

    function void decode_full(bit [FullW-1:0] w);
      bit [RunW-1:0]   run;
      bit [LimitW-1:0] room;
      bit              fin;
      out_item_t       r;
      if (done || decoded >= count_r) return;
      decoded = decoded + 24'd1;
      if (!len_next) begin
        cur_sample = w[SampleW-1:0];
        run = {36'd0, w[SampleW]} + 37'd1;
        len_next = w[LenFollowsBit];
      end else begin
        run = {w, 1'b0};
        len_next = 1'b0;
      end
      room = (limit_r > emitted) ? limit_r - emitted : '0;
      if ({11'd0, run} > room) begin
        run = room[RunW-1:0];
        clip_hits++;
      end
      emitted = emitted + {11'd0, run};
      fin = (emitted >= limit_r) || (decoded >= count_r);
      if (fin) done = 1'b1;
      if (run == '0 && !fin) return;
      if (run == '0) zero_runs++;
      if (fin) capture_ends++;
      r.sample_value = cur_sample;
      r.repeat_count = run;
      r.last = fin;
      runs_due.push_back(r);
    endfunction

    function void take_word(in_item_t it);
      words_sent++;
      if (it.capture_start) clear_capture();
      if (!done && decoded < count_r) words_live++;
      if (slot < WordsPerSlice) begin
        slice_words[slot] = it.mem_word;
        slot++;
        return;
      end
      slot = 0;
      for (int i = 0; i < WordsPerSlice; i++) begin
        decode_full({it.mem_word[WordW-1-NibW*i -: NibW], slice_words[i]});
      end
    endfunction

    function void check_run(out_item_t got);
      out_item_t want;
      if (runs_due.size() == 0) begin
        $error("unexpected run: sample_value %0h repeat_count %0h last %0b",
               got.sample_value, got.repeat_count, got.last);
        mismatches++;
        return;
      end
      want = runs_due.pop_front();
      runs_checked++;
      if (got.sample_value !== want.sample_value) begin
        $error("sample_value: expected %0h, got %0h", want.sample_value, got.sample_value);
        mismatches++;
      end
      if (got.repeat_count !== want.repeat_count) begin
        $error("repeat_count: expected %0h, got %0h", want.repeat_count, got.repeat_count);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_reg_e    cfg_index;
  logic [LimitW-1:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;

  run_tracker  scb;
  bit          calm = 1'b0;
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;
  bit          gen_len = 1'b0;
  bit [FullW-1:0] slice_w [WordsPerSlice];

  rle_capture_word_decoder_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #2_400_000;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) scb.check_run(out_data);
  end

  // result side back-pressure
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!calm && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Random capture word; keeps data / length word alternation when well formed.
  function bit [FullW-1:0] next_word();
    bit [31:0]      r0;
    bit [31:0]      r1;
    int unsigned    pick;
    bit [FullW-1:0] w;
    r0 = $urandom;
    r1 = $urandom;
    pick = $urandom_range(0, 9);
    if (gen_len) begin
      gen_len = 1'b0;
      if (pick == 0) w = '0;
      else if (pick < 3) w = {r1[3:0], 28'd0, r0[3:0]};
      else w = {r1[3:0], r0};
    end else begin
      w[LenFollowsBit] = (pick < 4);
      w[SampleW] = r1[31];
      if (pick == 4) w[SampleW-1:0] = '0;
      else if (pick == 5) w[SampleW-1:0] = '1;
      else w[SampleW-1:0] = {r1[1:0], r0};
      gen_len = w[LenFollowsBit];
    end
    return w;
  endfunction

  task automatic write_cfg(cfg_reg_e idx, bit [LimitW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    scb.write_reg(idx, val);
  endtask

  task automatic push_word(bit [WordW-1:0] w, bit st);
    in_item_t it;
    it.mem_word = w;
    it.capture_start = st;
    if (!calm && send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    scb.take_word(it);
  endtask

  // Sends slice_w as eight low words plus the nibble word; capture_start goes
  // on word start_at (0..8), none when start_at is 9.
  task automatic send_slice(int unsigned start_at);
    bit [WordW-1:0] nib;
    for (int i = 0; i < WordsPerSlice; i++) begin
      nib[WordW-1-NibW*i -: NibW] = slice_w[i][FullW-1:WordW];
      push_word(slice_w[i][WordW-1:0], start_at == i);
    end
    push_word(nib, start_at == WordsPerSlice);
  endtask

  task automatic settle_idle();
    in_valid <= 1'b0;
    while (scb.runs_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  initial begin
    int unsigned    sent_base;
    int unsigned    phase;
    int unsigned    kind;
    int unsigned    n_slices;
    int unsigned    pick;
    int unsigned    guard;
    bit             cont;
    bit [31:0]      r0;
    bit [31:0]      r1;
    bit [LimitW-1:0] lim;

    scb       = new();
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_SAMPLE_LIMIT;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: widest runs, dropped zero-length run, every word kind
    write_cfg(REG_SAMPLE_LIMIT, '1);
    write_cfg(REG_WORD_COUNT, {24'd0, 24'hFF_FFFF});
    cfg_valid <= 1'b0;
    slice_w[0] = {1'b1, 1'b1, {SampleW{1'b1}}};
    slice_w[1] = 36'hF_FFFF_FFFF;
    slice_w[2] = {1'b1, 1'b0, 34'h0};
    slice_w[3] = 36'h0;
    slice_w[4] = {1'b0, 1'b1, 34'h2_AAAA_AAAA};
    slice_w[5] = {1'b0, 1'b0, 34'h1_5555_5555};
    slice_w[6] = {1'b1, 1'b0, 34'h0_0F0F_0F0F};
    slice_w[7] = 36'h0_0000_0001;
    send_slice(0);
    settle_idle();

    // limit dropped to exactly what was emitted: zero-length last run
    write_cfg(REG_SAMPLE_LIMIT, scb.emitted);
    cfg_valid <= 1'b0;
    gen_len = 1'b0;
    for (int i = 0; i < WordsPerSlice; i++) slice_w[i] = next_word();
    send_slice(9);
    settle_idle();

    // run clipped by the limit, then the rest of the slice ignored
    write_cfg(REG_WORD_COUNT, {24'd0, 24'd5});
    write_cfg(REG_SAMPLE_LIMIT, 48'd6);
    cfg_valid <= 1'b0;
    gen_len = 1'b0;
    slice_w[0] = {1'b0, 1'b1, 34'h3_0000_0001};
    slice_w[1] = {1'b1, 1'b0, 34'h0_8000_0000};
    slice_w[2] = 36'd2;
    for (int i = 3; i < WordsPerSlice; i++) slice_w[i] = next_word();
    send_slice(0);
    settle_idle();

    sent_base = scb.words_sent;
    phase = 0;
    while (scb.words_sent - sent_base < WordGoal) begin
      if (scb.words_sent - sent_base + 60 >= WordGoal) calm = 1'b1;
      send_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : 25;
      stall_pct    = ($urandom_range(0, 3) == 0) ? 0 : 20;
      kind = $urandom_range(0, 9);
      cont = 1'b0;
      r0 = $urandom;
      r1 = $urandom;
      case (kind)
        0: begin
          write_cfg(REG_WORD_COUNT, '0);
          write_cfg(REG_SAMPLE_LIMIT, {r1[15:0], r0});
        end
        1: begin
          write_cfg(REG_SAMPLE_LIMIT, 48'd1);
          write_cfg(REG_WORD_COUNT, {24'd0, 24'hFF_FFFF});
        end
        2: begin
          write_cfg(REG_SAMPLE_LIMIT, '1);
          write_cfg(REG_WORD_COUNT, {24'd0, 24'hFF_FFFF});
        end
        3: begin
          // keep the readout going with the limit at or under what is out (1 when at most 3 are out)
          lim = (scb.emitted > 48'd3) ? scb.emitted - 48'($urandom_range(0, 3)) : 48'd1;
          write_cfg(REG_SAMPLE_LIMIT, lim);
          cont = 1'b1;
        end
        4, 5: begin
          write_cfg(REG_SAMPLE_LIMIT, 48'($urandom_range(1, 200)));
          write_cfg(REG_WORD_COUNT, 48'($urandom_range(1, 60)));
        end
        default: begin
          write_cfg(REG_SAMPLE_LIMIT, {r1[15:0], r0} | 48'd1);
          write_cfg(REG_WORD_COUNT,
                    (r1[31]) ? {24'd0, 24'hFF_FFFF} : 48'($urandom_range(1, 100)));
        end
      endcase
      cfg_valid <= 1'b0;
      gen_len = 1'b0;
      n_slices = $urandom_range(1, 5);
      for (int s = 0; s < n_slices; s++) begin
        pick = $urandom_range(0, 19);
        for (int i = 0; i < WordsPerSlice; i++) begin
          if (pick < 2) begin
            r0 = $urandom;
            r1 = $urandom;
            slice_w[i] = {r1[3:0], r0};
          end else begin
            slice_w[i] = next_word();
          end
        end
        if (pick >= 2 && pick < 5) send_slice($urandom_range(1, 8));
        else send_slice((s == 0 && !cont) ? 0 : 9);
        if (phase == 2 && s == 0) begin
          // hold the sender until the decoder has caught up
          in_valid <= 1'b0;
          do @(posedge clk); while (scb.runs_due.size() != 0);
        end
      end
      settle_idle();
      phase++;
    end

    in_valid <= 1'b0;
    guard = 0;
    while (scb.runs_due.size() != 0 && guard < 50_000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SettleCycles) @(posedge clk);
    if (scb.runs_due.size() != 0) begin
      $error("%0d runs never came out", scb.runs_due.size());
      scb.mismatches += scb.runs_due.size();
    end

    $display("Covered %0d phases, %0d words sent (%0d live), %0d runs checked.",
             phase + 3, scb.words_sent, scb.words_live, scb.runs_checked);
    $display("Runs clipped: %0d, zero-length last runs: %0d, readouts ended: %0d.",
             scb.clip_hits, scb.zero_runs, scb.capture_ends);
    if (scb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/rcwd_pkg.sv
rtl/core/rcwd_ram.sv
rtl/core/rle_capture_word_decoder_unit.sv
dv/rle_capture_word_decoder_unit_tb.sv
